// ===== design/abpw_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// abpw_pkg
// shared types and constants of the alpha blending pixel writer
// ---------------------------------------------------------------------------
package abpw_pkg;

    localparam int STORE_PIXELS_DEF = 65536;
    localparam int DIM_W            = 9;
    localparam int POS_W            = 16;
    localparam int IDX_W            = 18;   // y*width+x with 9-bit operands
    localparam int PIX_IDX_W        = 16;
    localparam int CFG_IDX_W        = 1;
    localparam int CFG_DATA_W       = 9;
    localparam int QUEUE_DEPTH      = 2;

    localparam logic [DIM_W-1:0] DIM_RESET = 9'd256;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic             ok;
        logic             blend;
        logic [IDX_W-1:0] idx;
        logic [7:0]       blue;
        logic [7:0]       green;
        logic [7:0]       red;
        logic [7:0]       alpha;
    } t_item;

    typedef struct packed {
        logic                 written;
        logic [PIX_IDX_W-1:0] pixel_index;
        logic [7:0]           blue;
        logic [7:0]           green;
        logic [7:0]           red;
        logic [7:0]           alpha;
        logic                 blended;
    } t_result;

endpackage
`default_nettype wire

// ===== design/abpw_front.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// abpw_front
// holds the frame size and classifies incoming pixel requests
// ---------------------------------------------------------------------------
module abpw_front #(
    parameter int STORE_PIXELS = abpw_pkg::STORE_PIXELS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_valid,
    input  wire logic [abpw_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [abpw_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic [abpw_pkg::POS_W-1:0]      i_pos_x,
    input  wire logic [abpw_pkg::POS_W-1:0]      i_pos_y,
    input  wire logic [7:0]                      i_new_blue,
    input  wire logic [7:0]                      i_new_green,
    input  wire logic [7:0]                      i_new_red,
    input  wire logic [7:0]                      i_new_alpha,
    input  wire logic                            i_blend_enable,
    output abpw_pkg::t_item                      o_item
);

    logic [abpw_pkg::DIM_W-1:0] r_width, r_height;
    logic                       in_x, in_y, neg;
    logic [abpw_pkg::IDX_W-1:0] idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= abpw_pkg::DIM_RESET;
            r_height <= abpw_pkg::DIM_RESET;
        end else if (i_cfg_valid) begin
            case (abpw_pkg::t_cfg_reg'(i_cfg_index))
                abpw_pkg::REG_WIDTH:  r_width  <= i_cfg_data;
                abpw_pkg::REG_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        neg  = i_pos_x[abpw_pkg::POS_W-1] | i_pos_y[abpw_pkg::POS_W-1];
        in_x = i_pos_x < abpw_pkg::POS_W'(r_width);
        in_y = i_pos_y < abpw_pkg::POS_W'(r_height);
        // inside the frame both coordinates fit in nine bits
        idx  = abpw_pkg::IDX_W'(i_pos_y[abpw_pkg::DIM_W-1:0]) * abpw_pkg::IDX_W'(r_width)
             + abpw_pkg::IDX_W'(i_pos_x[abpw_pkg::DIM_W-1:0]);
        o_item.ok    = !neg && in_x && in_y && (32'(idx) < 32'(STORE_PIXELS));
        o_item.blend = i_blend_enable;
        o_item.idx   = idx;
        o_item.blue  = i_new_blue;
        o_item.green = i_new_green;
        o_item.red   = i_new_red;
        o_item.alpha = i_new_alpha;
    end

endmodule
`default_nettype wire

// ===== design/abpw_queue.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// abpw_queue
// short queue between the classifying front and the blending back
// ---------------------------------------------------------------------------
module abpw_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire abpw_pkg::t_item i_item,
    output logic                 o_full,
    input  wire logic            i_pop,
    output logic                 o_valid,
    output abpw_pkg::t_item      o_item
);

    abpw_pkg::t_item r_slot [abpw_pkg::QUEUE_DEPTH];
    logic            r_wr, r_rd;
    logic [1:0]      r_count;

    assign o_full  = r_count == 2'(abpw_pkg::QUEUE_DEPTH);
    assign o_valid = r_count != 2'd0;
    assign o_item  = r_slot[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) r_slot[r_wr] <= i_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) r_wr <= ~r_wr;
            if (i_pop)  r_rd <= ~r_rd;
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== design/abpw_back.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// abpw_back
// frame store, compositing datapath and result register
// ---------------------------------------------------------------------------
module abpw_back #(
    parameter int STORE_PIXELS = abpw_pkg::STORE_PIXELS_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_q_valid,
    input  wire abpw_pkg::t_item i_q_item,
    output logic                 o_pop,
    output logic                 o_clearing,
    output logic                 o_valid,
    input  wire logic            i_stall,
    output abpw_pkg::t_result    o_result
);

    localparam int AW    = $clog2(STORE_PIXELS);
    localparam int NUM_W = 26;
    localparam int DEN_W = 24;

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_READ  = 7'b0000100,
        S_MUL   = 7'b0001000,
        S_SUM   = 7'b0010000,
        S_DIV   = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state                r_state, n_state;
    logic [AW-1:0]         r_clr;
    logic [31:0]           mem [STORE_PIXELS];
    logic [31:0]           r_rd;
    abpw_pkg::t_item       r_item;
    logic [AW-1:0]         addr;
    logic [15:0]           r_pc [3];
    logic [15:0]           r_p2, r_m;
    logic [NUM_W-1:0]      r_rem [3];
    logic [DEN_W-1:0]      r_den [3];
    logic [7:0]            r_q [4];
    logic [2:0]            r_step;
    logic                  r_blend;
    logic [7:0]            res_b, res_g, res_r, res_a;
    logic                  do_blend, finish;
    abpw_pkg::t_result     r_out;
    logic                  r_out_valid;
    logic [7:0]            prev [3];
    logic [7:0]            cur [3];
    logic [15:0]           d_val;

    assign addr       = AW'(r_item.idx);
    assign o_clearing = r_state == S_CLEAR;
    assign o_pop      = r_state == S_IDLE && i_q_valid;
    assign finish     = r_state == S_DONE && (!r_out_valid || !i_stall);
    assign do_blend   = r_item.blend && r_rd[31:24] != 8'd0;
    assign o_valid    = r_out_valid;
    assign o_result   = r_out;

    always_comb begin
        prev[0] = r_rd[7:0];
        prev[1] = r_rd[15:8];
        prev[2] = r_rd[23:16];
        cur[0]  = r_item.blue;
        cur[1]  = r_item.green;
        cur[2]  = r_item.red;
        d_val   = 16'd65025 - r_m;
        if (r_blend) begin
            res_b = r_q[0];
            res_g = r_q[1];
            res_r = r_q[2];
            res_a = r_q[3];
        end else begin
            res_b = r_item.blue;
            res_g = r_item.green;
            res_r = r_item.red;
            res_a = r_item.alpha;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (r_clr == AW'(STORE_PIXELS - 1)) n_state = S_IDLE;
            S_IDLE:  if (i_q_valid) n_state = i_q_item.ok ? S_READ : S_DONE;
            S_READ:  n_state = S_MUL;
            S_MUL:   n_state = do_blend ? S_SUM : S_DONE;
            S_SUM:   n_state = S_DIV;
            S_DIV:   if (r_step == 3'd7) n_state = S_DONE;
            S_DONE:  if (finish) n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) r_clr <= r_clr + AW'(1);
            if (finish)             r_out_valid <= 1'b1;
            else if (!i_stall)      r_out_valid <= 1'b0;
        end
    end

    // store: clearing sweep, read on request, write at completion
    always_ff @(posedge i_clk) begin
        if (r_state == S_CLEAR) begin
            mem[r_clr] <= 32'd0;
        end else if (finish && r_item.ok) begin
            mem[addr] <= {res_a, res_r, res_g, res_b};
        end
        if (r_state == S_READ) r_rd <= mem[addr];
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item  <= i_q_item;
            r_blend <= 1'b0;
        end
        if (r_state == S_MUL) begin
            r_blend <= do_blend;
            for (int c = 0; c < 3; c++) r_pc[c] <= 16'(cur[c]) * 16'(r_item.alpha);
            r_p2 <= 16'(r_rd[31:24]) * 16'(8'd255 - r_item.alpha);
            r_m  <= 16'(8'd255 - r_item.alpha) * 16'(8'd255 - r_rd[31:24]);
        end
        if (r_state == S_SUM) begin
            // rounded quotient as floor((2n + d) / 2d)
            for (int c = 0; c < 3; c++) begin
                r_rem[c] <= ((NUM_W'(r_pc[c]) * NUM_W'(255)
                            + NUM_W'(prev[c]) * NUM_W'(r_p2)) << 1) + NUM_W'(d_val);
                r_den[c] <= DEN_W'({d_val, 1'b0}) << 7;
            end
            // d / 255 by reciprocal, exact for d below 65535
            r_q[3] <= 8'((17'(d_val) + 17'd1 + 17'(d_val[15:8])) >> 8);
            r_step <= 3'd0;
        end
        if (r_state == S_DIV) begin
            for (int l = 0; l < 3; l++) begin
                if (r_rem[l] >= NUM_W'(r_den[l])) begin
                    r_rem[l] <= r_rem[l] - NUM_W'(r_den[l]);
                    r_q[l]   <= {r_q[l][6:0], 1'b1};
                end else begin
                    r_q[l]   <= {r_q[l][6:0], 1'b0};
                end
                r_den[l] <= r_den[l] >> 1;
            end
            r_step <= r_step + 3'd1;
        end
        if (finish) begin
            r_out.written     <= r_item.ok;
            r_out.pixel_index <= r_item.ok ? r_item.idx[15:0] : 16'd0;
            r_out.blue        <= r_item.ok ? res_b : 8'd0;
            r_out.green       <= r_item.ok ? res_g : 8'd0;
            r_out.red         <= r_item.ok ? res_r : 8'd0;
            r_out.alpha       <= r_item.ok ? res_a : 8'd0;
            r_out.blended     <= r_item.ok && r_blend;
        end
    end

    a_no_pop_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CLEAR |-> !o_pop)
        else $error("queue popped during clearing sweep");

    a_blend_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.blended |-> r_out.written)
        else $error("blended result not written");

    a_div_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SUM |=> ##8 r_state == S_DONE)
        else $error("divider did not finish in eight steps");

endmodule
`default_nettype wire

// ===== design/alpha_blend_pixel_writer_unit.sv =====
`default_nettype none
// path: a dropped pixel goes from IDLE to DONE, an overwrite through READ and MUL,
// a blend through READ, MUL, SUM and DIV, each then reaching DONE and the result register
// throughput: one request at a time in the back end;
// the eight-step quotient divider sets the blend time, the store read the overwrite time
// reset: synchronous active low; afterwards a sweep over all STORE_PIXELS entries
// clears the frame store, during which input requests are stalled
// ---------------------------------------------------------------------------
// alpha_blend_pixel_writer_unit
// writes bgra pixels into a frame store with optional alpha-over blending
// ---------------------------------------------------------------------------
module alpha_blend_pixel_writer_unit #(
    parameter int STORE_PIXELS = abpw_pkg::STORE_PIXELS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [abpw_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [abpw_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire logic                               i_valid,
    output logic                                    o_stall,
    input  wire logic [abpw_pkg::POS_W-1:0]         i_pos_x,
    input  wire logic [abpw_pkg::POS_W-1:0]         i_pos_y,
    input  wire logic [7:0]                         i_new_blue,
    input  wire logic [7:0]                         i_new_green,
    input  wire logic [7:0]                         i_new_red,
    input  wire logic [7:0]                         i_new_alpha,
    input  wire logic                               i_blend_enable,
    output logic                                    o_valid,
    input  wire logic                               i_stall,
    output logic                                    o_written,
    output logic [abpw_pkg::PIX_IDX_W-1:0]          o_pixel_index,
    output logic [7:0]                              o_out_blue,
    output logic [7:0]                              o_out_green,
    output logic [7:0]                              o_out_red,
    output logic [7:0]                              o_out_alpha,
    output logic                                    o_blended
);

    abpw_pkg::t_item   front_item, q_item;
    abpw_pkg::t_result result;
    logic              q_full, q_valid, pop, clearing, push;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = q_full || clearing;
    assign push        = i_valid && !o_stall;

    abpw_front #(.STORE_PIXELS(STORE_PIXELS)) u_front (
        .i_clk, .i_rst_n,
        .i_cfg_valid, .i_cfg_index, .i_cfg_data,
        .i_pos_x, .i_pos_y, .i_new_blue, .i_new_green, .i_new_red,
        .i_new_alpha, .i_blend_enable,
        .o_item (front_item)
    );

    abpw_queue u_queue (
        .i_clk, .i_rst_n,
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    abpw_back #(.STORE_PIXELS(STORE_PIXELS)) u_back (
        .i_clk, .i_rst_n,
        .i_q_valid  (q_valid),
        .i_q_item   (q_item),
        .o_pop      (pop),
        .o_clearing (clearing),
        .o_valid,
        .i_stall,
        .o_result   (result)
    );

    assign o_written     = result.written;
    assign o_pixel_index = result.pixel_index;
    assign o_out_blue    = result.blue;
    assign o_out_green   = result.green;
    assign o_out_red     = result.red;
    assign o_out_alpha   = result.alpha;
    assign o_blended     = result.blended;

endmodule
`default_nettype wire

// ===== dv/tb_alpha_blend_pixel_writer_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_alpha_blend_pixel_writer_unit
// drives pixel write requests under several frame geometries and idling
// patterns; a local frame store model predicts each written pixel and the
// alpha-over blend, and every result is compared field by field in order
// ---------------------------------------------------------------------------
module tb_alpha_blend_pixel_writer_unit;

    localparam int    NPIX      = 65536;
    localparam int    SETTLE    = 24;
    localparam longint CYC_LIMIT = 3000000;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [abpw_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [abpw_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                            i_valid = 1'b0;
    logic                            o_stall;
    logic [abpw_pkg::POS_W-1:0]      i_pos_x = '0;
    logic [abpw_pkg::POS_W-1:0]      i_pos_y = '0;
    logic [7:0]                      i_new_blue = '0;
    logic [7:0]                      i_new_green = '0;
    logic [7:0]                      i_new_red = '0;
    logic [7:0]                      i_new_alpha = '0;
    logic                            i_blend_enable = 1'b0;
    logic                            o_valid;
    logic                            i_stall = 1'b0;
    logic                            o_written;
    logic [abpw_pkg::PIX_IDX_W-1:0]  o_pixel_index;
    logic [7:0]                      o_out_blue;
    logic [7:0]                      o_out_green;
    logic [7:0]                      o_out_red;
    logic [7:0]                      o_out_alpha;
    logic                            o_blended;

    alpha_blend_pixel_writer_unit uut (.*);

    always #5 i_clk = ~i_clk;

    // predictor state
    logic [31:0]        pix_mem [NPIX];
    int unsigned        cur_width = 256;
    int unsigned        cur_height = 256;
    abpw_pkg::t_result  pending_px [$];

    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;
    int            hold_cycles = 0;
    int            fails = 0;
    int            n_sent = 0;
    int            n_blend = 0;
    int            n_drop = 0;
    longint        cycles = 0;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYC_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // receiver stall, with a long hold-off when requested
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            i_stall     <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    function automatic logic [7:0] mix_ch(int unsigned cur, int unsigned prev,
                                          int unsigned ca, int unsigned pa,
                                          longint unsigned d);
        longint unsigned n;
        n = longint'(cur) * ca * 255 + longint'(prev) * pa * (255 - ca);
        return 8'((2 * n + d) / (2 * d));
    endfunction

    function automatic abpw_pkg::t_result write_pixel(logic [15:0] px, logic [15:0] py,
                                                      logic [7:0] b, logic [7:0] g,
                                                      logic [7:0] r, logic [7:0] a,
                                                      logic be);
        abpw_pkg::t_result res;
        int                sx, sy;
        longint unsigned   idx, d;
        logic [31:0]       prev;
        int unsigned       pa;
        res = '0;
        sx  = $signed(px);
        sy  = $signed(py);
        if (sx < 0 || sy < 0 || sx >= cur_width || sy >= cur_height)
            return res;
        idx = longint'(sy) * cur_width + sx;
        if (idx >= NPIX)
            return res;
        prev = pix_mem[idx];
        pa   = prev[31:24];
        if (be && pa != 0) begin
            d = 65025 - longint'(255 - a) * (255 - pa);
            b = mix_ch(b, prev[7:0], a, pa, d);
            g = mix_ch(g, prev[15:8], a, pa, d);
            r = mix_ch(r, prev[23:16], a, pa, d);
            a = 8'(d / 255);
            res.blended = 1'b1;
        end
        pix_mem[idx]    = {a, r, g, b};
        res.written     = 1'b1;
        res.pixel_index = idx[15:0];
        res.blue        = b;
        res.green       = g;
        res.red         = r;
        res.alpha       = a;
        return res;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        abpw_pkg::t_result exp_px;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_px.size() == 0) begin
                $error("unexpected result, index %0d", o_pixel_index);
                fails++;
            end else begin
                exp_px = pending_px.pop_front();
                if (o_written !== exp_px.written) begin
                    $error("written exp %0d got %0d", exp_px.written, o_written);
                    fails++;
                end
                if (o_pixel_index !== exp_px.pixel_index) begin
                    $error("pixel_index exp %0d got %0d", exp_px.pixel_index,
                           o_pixel_index);
                    fails++;
                end
                if (o_out_blue !== exp_px.blue) begin
                    $error("out_blue exp %0d got %0d", exp_px.blue, o_out_blue);
                    fails++;
                end
                if (o_out_green !== exp_px.green) begin
                    $error("out_green exp %0d got %0d", exp_px.green, o_out_green);
                    fails++;
                end
                if (o_out_red !== exp_px.red) begin
                    $error("out_red exp %0d got %0d", exp_px.red, o_out_red);
                    fails++;
                end
                if (o_out_alpha !== exp_px.alpha) begin
                    $error("out_alpha exp %0d got %0d", exp_px.alpha, o_out_alpha);
                    fails++;
                end
                if (o_blended !== exp_px.blended) begin
                    $error("blended exp %0d got %0d", exp_px.blended, o_blended);
                    fails++;
                end
            end
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_pixel(logic [15:0] px, logic [15:0] py, logic [7:0] b,
                              logic [7:0] g, logic [7:0] r, logic [7:0] a,
                              logic be);
        abpw_pkg::t_result res;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_pos_x        <= px;
        i_pos_y        <= py;
        i_new_blue     <= b;
        i_new_green    <= g;
        i_new_red      <= r;
        i_new_alpha    <= a;
        i_blend_enable <= be;
        do
            @(posedge i_clk);
        while (o_stall);
        res = write_pixel(px, py, b, g, r, a, be);
        if (res.blended) n_blend++;
        if (!res.written) n_drop++;
        n_sent++;
        pending_px.push_back(res);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending_px.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic set_geometry(int unsigned w, int unsigned h);
        abpw_pkg::t_cfg_reg sel;
        drain();
        for (int k = 0; k < 2; k++) begin
            sel = (k == 0) ? abpw_pkg::REG_WIDTH : abpw_pkg::REG_HEIGHT;
            i_cfg_valid <= 1'b1;
            i_cfg_index <= sel;
            i_cfg_data  <= (sel == abpw_pkg::REG_WIDTH) ? w[8:0] : h[8:0];
            do
                @(posedge i_clk);
            while (!o_cfg_ready);
            @(negedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        cur_width  = w & 9'h1FF;
        cur_height = h & 9'h1FF;
    endtask

    task automatic send_random();
        logic [15:0] px, py;
        logic [7:0]  a;
        int          pick;
        pick = $urandom_range(0, 19);
        if (pick == 0 || cur_width == 0 || cur_height == 0) begin
            px = 16'($urandom);
            py = 16'($urandom);
        end else if (pick == 1) begin
            // just past an edge of the frame
            px = $urandom_range(0, 1) ? 16'(cur_width + $urandom_range(0, 3))
                                      : 16'(-$urandom_range(1, 3));
            py = 16'($urandom_range(0, cur_height - 1));
        end else if (pick == 2) begin
            px = 16'($urandom_range(0, cur_width - 1));
            py = $urandom_range(0, 1) ? 16'(cur_height + $urandom_range(0, 3))
                                      : 16'(-$urandom_range(1, 3));
        end else begin
            // keep hits dense so blends land on written pixels
            px = 16'($urandom_range(0, (cur_width > 12 ? 11 : cur_width - 1)));
            py = 16'($urandom_range(0, (cur_height > 12 ? 11 : cur_height - 1)));
            if (pick == 3) begin
                px = 16'($urandom_range(0, cur_width - 1));
                py = 16'($urandom_range(0, cur_height - 1));
            end
        end
        case ($urandom_range(0, 5))
            0:       a = 8'd0;
            1:       a = 8'd255;
            default: a = 8'($urandom);
        endcase
        send_pixel(px, py, 8'($urandom), 8'($urandom), 8'($urandom), a,
                   $urandom_range(0, 3) != 0);
    endtask

    task automatic test_directed();
        set_geometry(256, 256);
        send_pixel(16'd0, 16'd0, 8'hFF, 8'h00, 8'hFF, 8'h00, 1'b1); // blend on empty
        send_pixel(16'd0, 16'd0, 8'h10, 8'h20, 8'h30, 8'h80, 1'b0);
        send_pixel(16'd0, 16'd0, 8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b1); // transparent new
        send_pixel(16'd0, 16'd0, 8'h00, 8'h00, 8'h00, 8'hFF, 1'b1); // opaque new
        send_pixel(16'd255, 16'd255, 8'hAA, 8'h55, 8'hAA, 8'hFF, 1'b0);
        send_pixel(16'd255, 16'd255, 8'h55, 8'hAA, 8'h55, 8'h7F, 1'b1);
        send_pixel(16'd256, 16'd0, 8'h01, 8'h02, 8'h03, 8'h04, 1'b0);
        send_pixel(16'd0, 16'd256, 8'h01, 8'h02, 8'h03, 8'h04, 1'b0);
        send_pixel(16'hFFFF, 16'd0, 8'h01, 8'h02, 8'h03, 8'h04, 1'b0);
        send_pixel(16'd0, 16'h8000, 8'h01, 8'h02, 8'h03, 8'h04, 1'b1);
        send_pixel(16'h7FFF, 16'h7FFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        send_pixel(16'h8000, 16'h7FFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        send_pixel(16'd17, 16'd200, 8'h01, 8'h01, 8'h01, 8'h01, 1'b0);
        send_pixel(16'd17, 16'd200, 8'hFE, 8'hFE, 8'hFE, 8'h01, 1'b1);
        set_geometry(0, 5);                                        // nothing fits
        send_pixel(16'd0, 16'd0, 8'h11, 8'h22, 8'h33, 8'h44, 1'b0);
        set_geometry(7, 0);
        send_pixel(16'd0, 16'd0, 8'h11, 8'h22, 8'h33, 8'h44, 1'b0);
        set_geometry(511, 511);                                    // past the store
        send_pixel(16'd510, 16'd510, 8'h11, 8'h22, 8'h33, 8'h44, 1'b0);
        send_pixel(16'd0, 16'd128, 8'h11, 8'h22, 8'h33, 8'h44, 1'b0);
        send_pixel(16'd127, 16'd128, 8'h11, 8'h22, 8'h33, 8'h44, 1'b0);
        send_pixel(16'd128, 16'd128, 8'h11, 8'h22, 8'h33, 8'h44, 1'b0);
        set_geometry(1, 1);
        send_pixel(16'd0, 16'd0, 8'hC0, 8'h40, 8'h80, 8'h01, 1'b0);
        send_pixel(16'd0, 16'd0, 8'h3F, 8'hBF, 8'h7F, 8'hFE, 1'b1);
        send_pixel(16'd1, 16'd0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
    endtask

    task automatic test_random_geometries();
        int unsigned dims [7][2] = '{'{16, 16}, '{256, 256}, '{1, 1}, '{300, 200},
                                     '{7, 3}, '{511, 511}, '{1, 256}};
        int idle_mode [4][2] = '{'{0, 0}, '{54, 0}, '{0, 54}, '{27, 27}};
        foreach (dims[i]) begin
            set_geometry(dims[i][0], dims[i][1]);
            foreach (idle_mode[m]) begin
                send_idle_pct  = idle_mode[m][0];
                recv_stall_pct = idle_mode[m][1];
                repeat (58) send_random();
            end
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    task automatic test_backpressure();
        set_geometry(8, 8);
        hold_cycles = 300;
        repeat (20) send_random();
        drain();
        // sender waits for every result before going on
        repeat (10) begin
            send_random();
            drain();
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        foreach (pix_mem[k]) pix_mem[k] = '0;
        test_directed();
        test_random_geometries();
        test_backpressure();
        drain();
        $display("covered %0d pixel requests: %0d blended, %0d dropped,", n_sent,
                 n_blend, n_drop);
        $display("over frame sizes from 0 to 511 and four idling patterns");
        if (fails == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
